>>> hdl/vci_pkg.sv
// Shared constants, types and a lane helper for the velocity curve interpolator.
package vci_pkg;

    localparam int MAX_POINTS = 8;
    localparam int VEL_W      = 7;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 4;
    localparam int LANES_W    = MAX_POINTS * VEL_W;
    localparam int PROD_W     = 2 * VEL_W;
    localparam int STEP_W     = $clog2(VEL_W);
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 5;

    localparam logic [CNT_W-1:0]  COUNT_CAP = CNT_W'(MAX_POINTS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VEL_W - 1);

    localparam logic [1:0] REG_COUNT   = 2'd0;
    localparam logic [1:0] REG_INPUTS  = 2'd1;
    localparam logic [1:0] REG_OUTPUTS = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    function automatic logic [VEL_W-1:0] lane_of(input logic [LANES_W-1:0] word,
                                                 input logic [IDX_W-1:0] idx);
        lane_of = word[idx*VEL_W +: VEL_W];
    endfunction

endpackage

>>> hdl/velocity_curve_interpolator_top.sv
// Velocity curve interpolator: breakpoint registers, segment search and serial divide.
//
// Usage: the input channel (i_in_valid, i_velocity_in, o_in_stall) takes one
// note velocity per transfer; the output channel (o_out_valid, o_velocity_out,
// i_out_stall) gives exactly one shaped velocity per input transfer, in order.
// The curve is held in three registers on the APB-style port: the point count
// at byte address 0, the packed input lanes at 8 and the packed output lanes at
// 16. They should be written only while the block is idle.
// An item that an end point or the pass-through decides at once goes to the done
// state and then to the output register; otherwise the sequencer runs a segment
// search, one segment per cycle, which either ends without interpolation or goes
// on to shift-and-add multiplication and restoring division, one quotient bit per
// cycle, and then loads the output register. The next item is taken once the
// sequencer is back in idle.
// Reset clears the registers to zero, so the block starts in pass-through.
// A finished result waits in the output register while the receiver stalls;
// the sequencer can still take and work on the next item, and holds its own
// result until the output register is free.
module velocity_curve_interpolator_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [vci_pkg::VEL_W-1:0]    i_velocity_in,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output logic [vci_pkg::VEL_W-1:0]    o_velocity_out,
    input  logic                         i_out_stall,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vci_pkg::ADDR_W-1:0]   paddr,
    input  logic [vci_pkg::DATA_W-1:0]   pwdata,
    output logic [vci_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import vci_pkg::*;

    logic [CNT_W-1:0]   r_count;
    logic [LANES_W-1:0] r_inputs;
    logic [LANES_W-1:0] r_outputs;

    t_state             r_state, n_state;
    logic [VEL_W-1:0]   r_v, n_v;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic [VEL_W-1:0]   r_a, n_a;
    logic [PROD_W-1:0]  r_mc, n_mc;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [VEL_W:0]     r_rem, n_rem;
    logic [VEL_W-1:0]   r_q, n_q;
    logic [VEL_W-1:0]   r_span, n_span;
    logic [VEL_W-1:0]   r_y0, n_y0;
    logic               r_up, n_up;
    logic [VEL_W-1:0]   r_res, n_res;
    logic               r_out_valid, n_out_valid;
    logic [VEL_W-1:0]   r_out_data, n_out_data;

    logic               cfg_write;
    logic               in_take;
    logic               out_take;
    logic [CNT_W-1:0]   n_sat;
    logic [IDX_W-1:0]   last_idx;
    logic [VEL_W-1:0]   first_in;
    logic [VEL_W-1:0]   last_in;
    logic [IDX_W-1:0]   next_idx;
    logic               seg_end;
    logic [VEL_W-1:0]   x0, x1, y0, y1;
    logic [PROD_W-1:0]  prod_sum;
    logic [VEL_W:0]     trial;
    logic               ge;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_inputs  <= '0;
            r_outputs <= '0;
        end else if (cfg_write) begin
            unique case (paddr[ADDR_W-1:3])
                REG_COUNT:   r_count   <= pwdata[CNT_W-1:0];
                REG_INPUTS:  r_inputs  <= pwdata[LANES_W-1:0];
                REG_OUTPUTS: r_outputs <= pwdata[LANES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1:3])
            REG_COUNT:   prdata = {{(DATA_W-CNT_W){1'b0}}, r_count};
            REG_INPUTS:  prdata = {{(DATA_W-LANES_W){1'b0}}, r_inputs};
            REG_OUTPUTS: prdata = {{(DATA_W-LANES_W){1'b0}}, r_outputs};
            default:     prdata = '0;
        endcase
    end

    // Handshakes
    assign o_in_stall     = (r_state != S_IDLE);
    assign in_take        = i_in_valid && !o_in_stall;
    assign out_take       = r_out_valid && !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_velocity_out = r_out_data;

    // Datapath terms
    assign n_sat    = (r_count > COUNT_CAP) ? COUNT_CAP : r_count;
    assign last_idx = IDX_W'(n_sat - CNT_W'(1));
    assign first_in = lane_of(r_inputs, '0);
    assign last_in  = lane_of(r_inputs, last_idx);
    assign next_idx = r_idx + IDX_W'(1);
    assign seg_end  = ({1'b0, r_idx} + CNT_W'(1)) >= r_n;
    assign x0       = lane_of(r_inputs, r_idx);
    assign x1       = lane_of(r_inputs, next_idx);
    assign y0       = lane_of(r_outputs, r_idx);
    assign y1       = lane_of(r_outputs, next_idx);
    assign prod_sum = r_prod + (r_a[0] ? r_mc : '0);
    assign trial    = {r_rem[VEL_W-1:0], r_prod[PROD_W-1]};
    assign ge       = trial >= {1'b0, r_span};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_v        <= n_v;
        r_n        <= n_n;
        r_idx      <= n_idx;
        r_cnt      <= n_cnt;
        r_a        <= n_a;
        r_mc       <= n_mc;
        r_prod     <= n_prod;
        r_rem      <= n_rem;
        r_q        <= n_q;
        r_span     <= n_span;
        r_y0       <= n_y0;
        r_up       <= n_up;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_n         = r_n;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_a         = r_a;
        n_mc        = r_mc;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_q         = r_q;
        n_span      = r_span;
        n_y0        = r_y0;
        n_up        = r_up;
        n_res       = r_res;
        n_out_valid = r_out_valid && !out_take;
        n_out_data  = r_out_data;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_v   = i_velocity_in;
                    n_n   = n_sat;
                    n_idx = '0;
                    priority if (n_sat == '0) begin
                        n_res   = i_velocity_in;
                        n_state = S_DONE;
                    end else if (i_velocity_in <= first_in) begin
                        n_res   = lane_of(r_outputs, '0);
                        n_state = S_DONE;
                    end else if (i_velocity_in >= last_in) begin
                        n_res   = lane_of(r_outputs, last_idx);
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                priority if (seg_end) begin
                    n_res   = r_v;
                    n_state = S_DONE;
                end else if (r_v >= x0 && r_v <= x1) begin
                    if (x1 == x0) begin
                        n_res   = y0;
                        n_state = S_DONE;
                    end else begin
                        n_span  = x1 - x0;
                        n_y0    = y0;
                        n_up    = (y1 >= y0);
                        n_a     = r_v - x0;
                        n_mc    = {{VEL_W{1'b0}}, ((y1 >= y0) ? (y1 - y0) : (y0 - y1))};
                        n_prod  = '0;
                        n_cnt   = '0;
                        n_state = S_MUL;
                    end
                end else begin
                    n_idx = next_idx;
                end
            end
            S_MUL: begin
                n_a    = r_a >> 1;
                n_mc   = r_mc << 1;
                n_prod = prod_sum;
                n_cnt  = r_cnt + STEP_W'(1);
                if (r_cnt == LAST_STEP) begin
                    // The quotient never exceeds the rise, so the upper half
                    // already lies below the divisor.
                    n_rem   = {1'b0, prod_sum[PROD_W-1:VEL_W]};
                    n_prod  = {prod_sum[VEL_W-1:0], {VEL_W{1'b0}}};
                    n_q     = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = ge ? (trial - {1'b0, r_span}) : trial;
                n_q    = {r_q[VEL_W-2:0], ge};
                n_prod = r_prod << 1;
                n_cnt  = r_cnt + STEP_W'(1);
                if (r_cnt == LAST_STEP) begin
                    n_res   = r_up ? (r_y0 + {r_q[VEL_W-2:0], ge})
                                   : (r_y0 - {r_q[VEL_W-2:0], ge});
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || out_take) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Checks
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state != S_IDLE))
        else $error("accepted transfer did not start the sequencer");

    a_scan_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_n >= CNT_W'(2)))
        else $error("segment search with fewer than two points");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < {1'b0, r_span}))
        else $error("division remainder not below the divisor");

    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_DIV) |-> (r_span != '0))
        else $error("interpolation started on a zero-width segment");

endmodule

>>> tb/velocity_curve_checker.sv
// Checker that tracks the curve registers, predicts each shaped velocity and compares results.
module velocity_curve_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [vci_pkg::VEL_W-1:0]    i_velocity_in,
    input  logic                         i_in_stall,
    input  logic                         i_out_valid,
    input  logic [vci_pkg::VEL_W-1:0]    i_velocity_out,
    input  logic                         i_out_stall,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [vci_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [vci_pkg::DATA_W-1:0]   i_pwdata,
    input  logic                         i_pready,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import vci_pkg::*;

    logic [CNT_W-1:0]   curve_count   = '0;
    logic [LANES_W-1:0] curve_inputs  = '0;
    logic [LANES_W-1:0] curve_outputs = '0;
    logic [VEL_W-1:0]   shaped_queue[$];
    int                 fail_total    = 0;
    int                 pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    function automatic int point_lane(input logic [LANES_W-1:0] word, input int k);
        return int'(word[k*VEL_W +: VEL_W]);
    endfunction

    function automatic logic [VEL_W-1:0] shape_velocity(input logic [VEL_W-1:0] vel);
        int v;
        int used;
        int x0;
        int x1;
        int y0;
        int y1;
        int offset;
        v    = int'(vel);
        used = (curve_count > COUNT_CAP) ? MAX_POINTS : int'(curve_count);
        if (used == 0) begin
            return vel;
        end
        if (v <= point_lane(curve_inputs, 0)) begin
            return VEL_W'(point_lane(curve_outputs, 0));
        end
        if (v >= point_lane(curve_inputs, used - 1)) begin
            return VEL_W'(point_lane(curve_outputs, used - 1));
        end
        for (int k = 0; k + 1 < used; k++) begin
            x0 = point_lane(curve_inputs, k);
            x1 = point_lane(curve_inputs, k + 1);
            if (v >= x0 && v <= x1) begin
                y0 = point_lane(curve_outputs, k);
                y1 = point_lane(curve_outputs, k + 1);
                if (x1 == x0) begin
                    return VEL_W'(y0);
                end
                offset = ((v - x0) * ((y1 >= y0) ? (y1 - y0) : (y0 - y1))) / (x1 - x0);
                return VEL_W'((y1 >= y0) ? (y0 + offset) : (y0 - offset));
            end
        end
        return vel;
    endfunction

    task automatic report_mismatch(input string what, input logic [VEL_W-1:0] want,
                                   input logic [VEL_W-1:0] got);
        $display("%0t: mismatch on %s: wanted %0d, got %0d", $realtime, what, want, got);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        logic [VEL_W-1:0] wanted;
        if (!i_rst_n) begin
            curve_count   = '0;
            curve_inputs  = '0;
            curve_outputs = '0;
            shaped_queue.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:3])
                    REG_COUNT:   curve_count   = i_pwdata[CNT_W-1:0];
                    REG_INPUTS:  curve_inputs  = i_pwdata[LANES_W-1:0];
                    REG_OUTPUTS: curve_outputs = i_pwdata[LANES_W-1:0];
                    default: ;
                endcase
            end
            // A result transfer always belongs to an earlier input, so it is matched first.
            if (i_out_valid && !i_out_stall) begin
                if (shaped_queue.size() == 0) begin
                    report_mismatch("unexpected result transfer", '0, i_velocity_out);
                end else begin
                    wanted = shaped_queue.pop_front();
                    if (i_velocity_out !== wanted) begin
                        report_mismatch("velocity_out", wanted, i_velocity_out);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                shaped_queue.push_back(shape_velocity(i_velocity_in));
            end
        end
        pending_total <= shaped_queue.size();
    end

endmodule

>>> tb/tb.sv
// Testbench top: clock, reset, curve configuration, velocity stimulus and the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vci_pkg::*;

    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int DRAIN_CYCLES    = 30;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               in_valid    = 1'b0;
    logic [VEL_W-1:0]   velocity_in = '0;
    logic               in_stall;
    logic               out_valid;
    logic [VEL_W-1:0]   velocity_out;
    logic               out_stall   = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [ADDR_W-1:0]  paddr       = '0;
    logic [DATA_W-1:0]  pwdata      = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    logic               idle_on     = 1'b0;
    int                 stall_left  = 0;
    int                 cycle_count = 0;
    int                 fail_count;
    int                 pending;
    logic [LANES_W-1:0] cur_inputs  = '0;

    velocity_curve_interpolator_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_velocity_in  (velocity_in),
        .o_in_stall     (in_stall),
        .o_out_valid    (out_valid),
        .o_velocity_out (velocity_out),
        .i_out_stall    (out_stall),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    velocity_curve_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_velocity_in  (velocity_in),
        .i_in_stall     (in_stall),
        .i_out_valid    (out_valid),
        .i_velocity_out (velocity_out),
        .i_out_stall    (out_stall),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Waits until every predicted velocity has been taken by the receiver.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic apply_curve(input logic [CNT_W-1:0] count, input logic [LANES_W-1:0] ins,
                               input logic [LANES_W-1:0] outs);
        settle();
        write_reg(REG_COUNT, DATA_W'(count));
        write_reg(REG_INPUTS, DATA_W'(ins));
        write_reg(REG_OUTPUTS, DATA_W'(outs));
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        cur_inputs = ins;
    endtask

    task automatic send_velocity(input logic [VEL_W-1:0] v);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap      = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        velocity_in <= v;
        do @(posedge i_clk); while (in_stall);
    endtask

    function automatic logic [CNT_W-1:0] random_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CNT_W'(1);
            2:       return CNT_W'($urandom_range(MAX_POINTS + 1, (1 << CNT_W) - 1));
            default: return CNT_W'($urandom_range(2, MAX_POINTS));
        endcase
    endfunction

    // Mostly sorted breakpoints, some with repeated inputs, a few unsorted or at the extremes.
    function automatic logic [LANES_W-1:0] random_inputs();
        int                 pts[MAX_POINTS];
        int                 mode;
        int                 k;
        int                 tmp;
        logic [LANES_W-1:0] word;
        mode = $urandom_range(0, 9);
        if (mode == 8) begin
            return LANES_W'({$urandom(), $urandom()});
        end
        for (int i = 0; i < MAX_POINTS; i++) begin
            pts[i] = (mode == 9) ? 127 * $urandom_range(0, 1) : $urandom_range(0, 127);
        end
        if (mode == 7) begin
            k      = $urandom_range(1, MAX_POINTS - 1);
            pts[k] = pts[k-1];
        end
        for (int i = 1; i < MAX_POINTS; i++) begin
            for (int j = i; j > 0 && pts[j-1] > pts[j]; j--) begin
                tmp      = pts[j];
                pts[j]   = pts[j-1];
                pts[j-1] = tmp;
            end
        end
        for (int i = 0; i < MAX_POINTS; i++) begin
            word[i*VEL_W +: VEL_W] = VEL_W'(pts[i]);
        end
        return word;
    endfunction

    function automatic logic [LANES_W-1:0] random_outputs();
        logic [LANES_W-1:0] word;
        case ($urandom_range(0, 9))
            0: word = '1;
            1: word = '0;
            2: begin
                for (int i = 0; i < MAX_POINTS; i++) begin
                    word[i*VEL_W +: VEL_W] = (i % 2 == 0) ? VEL_W'(127) : VEL_W'(0);
                end
            end
            default: word = LANES_W'({$urandom(), $urandom()});
        endcase
        return word;
    endfunction

    // A quarter of the velocities land on or next to a breakpoint input.
    function automatic logic [VEL_W-1:0] pick_velocity();
        int base;
        if ($urandom_range(0, 3) == 0) begin
            base = int'(cur_inputs[$urandom_range(0, MAX_POINTS - 1)*VEL_W +: VEL_W]);
            base = base + $urandom_range(0, 2) - 1;
            if (base < 0) begin
                base = 0;
            end
            if (base > 127) begin
                base = 127;
            end
            return VEL_W'(base);
        end
        return VEL_W'($urandom_range(0, 127));
    endfunction

    initial begin
        int pass_probes[4]   = '{0, 127, 85, 42};
        int single_probes[2] = '{0, 127};
        int seg_probes[9]    = '{0, 10, 11, 39, 40, 41, 99, 100, 127};
        int full_probes[5]   = '{1, 17, 64, 126, 127};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on <= 1'b1;

        foreach (pass_probes[i]) send_velocity(VEL_W'(pass_probes[i]));

        apply_curve(CNT_W'(1), LANES_W'(7'd64), LANES_W'(7'd99));
        foreach (single_probes[i]) send_velocity(VEL_W'(single_probes[i]));

        apply_curve(CNT_W'(4), LANES_W'({7'd100, 7'd40, 7'd40, 7'd10}),
                    LANES_W'({7'd0, 7'd127, 7'd120, 7'd5}));
        foreach (seg_probes[i]) send_velocity(VEL_W'(seg_probes[i]));

        apply_curve('1,
                    {7'd127, 7'd108, 7'd90, 7'd72, 7'd54, 7'd36, 7'd18, 7'd0},
                    {7'd0, 7'd127, 7'd0, 7'd127, 7'd0, 7'd127, 7'd0, 7'd127});
        foreach (full_probes[i]) send_velocity(VEL_W'(full_probes[i]));

        for (int p = 0; p < PHASES; p++) begin
            apply_curve(random_count(), random_inputs(), random_outputs());
            idle_on <= (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_velocity(pick_velocity());
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
